// ===== rtl/mwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared types and constants of the five-word multiply-with-carry generator.
// ----------------------------------------------------------------------------
package mwc_pkg;

    localparam int unsigned WORD_W = 32;

    // Generator multipliers, oldest history word last.
    localparam logic [12:0] MUL0 = 13'd5115;
    localparam logic [10:0] MUL1 = 11'd1776;
    localparam logic [10:0] MUL2 = 11'd1492;
    localparam logic [30:0] MUL3 = 31'd2111111111;

    localparam logic [24:0] SEED_MUL = 25'd29943829;

    localparam logic [4:0] SEED_WORDS   = 5'd5;
    localparam logic [4:0] WARMUP_STEPS = 5'd19;

    localparam logic [WORD_W-1:0] RESET_H0    = 32'h95d3474b;
    localparam logic [WORD_W-1:0] RESET_H1    = 32'h035cf1f7;
    localparam logic [WORD_W-1:0] RESET_H2    = 32'hfd43995f;
    localparam logic [WORD_W-1:0] RESET_H3    = 32'h5dfc55fb;
    localparam logic [WORD_W-1:0] RESET_CARRY = 32'h334a9229;

    typedef enum logic
    {
        CMD_NEXT   = 1'b0,
        CMD_RESEED = 1'b1
    } cmd_code_t;

    // One queued command as the front end classified it.
    typedef struct packed
    {
        cmd_code_t         code;
        logic [WORD_W-1:0] seed;
    } cmd_t;

    // Queue head as seen by the back end.
    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    // Back-end control and status toward the queue and top level.
    typedef struct packed
    {
        logic pop;
        logic busy;
    } core_ctrl_t;

endpackage

// ===== rtl/mwc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_queue
// Front end: accepts command transactions, classifies them and holds them in
// a short queue until the generator core takes them.
// ----------------------------------------------------------------------------
module mwc_queue #(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [mwc_pkg::WORD_W-1:0] seed,
    output mwc_pkg::queue_head_t       head,
    input  mwc_pkg::core_ctrl_t        ctrl
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mwc_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;
    mwc_pkg::cmd_t    in_cmd;

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;
    assign pop      = ctrl.pop && (count_reg != '0);

    assign in_cmd.code = command ? mwc_pkg::CMD_RESEED : mwc_pkg::CMD_NEXT;
    assign in_cmd.seed = seed;

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/mwc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwc_core
// Back end: runs the generator steps and the seeding sequence, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module mwc_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwc_pkg::queue_head_t       head,
    output mwc_pkg::core_ctrl_t        ctrl,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mwc_pkg::WORD_W-1:0] random_word
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEED,
        ST_PROD,
        ST_SUM
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [4:0]                 cnt_reg;
    logic [4:0]                 cnt_next;
    logic                       warm_reg;
    logic                       warm_next;
    logic [mwc_pkg::WORD_W-1:0] h_reg [4];
    logic [mwc_pkg::WORD_W-1:0] h_next [4];
    logic [mwc_pkg::WORD_W-1:0] carry_reg;
    logic [mwc_pkg::WORD_W-1:0] carry_next;
    logic [mwc_pkg::WORD_W-1:0] s_reg;
    logic [mwc_pkg::WORD_W-1:0] s_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [mwc_pkg::WORD_W-1:0] word_reg;
    logic [mwc_pkg::WORD_W-1:0] word_next;

    logic [44:0]                p0_reg;
    logic [42:0]                p1_reg;
    logic [42:0]                p2_reg;
    logic [62:0]                p3_reg;
    logic [63:0]                sum;
    logic [mwc_pkg::WORD_W-1:0] seed_prod;
    logic [mwc_pkg::WORD_W-1:0] seed_val;
    logic                       pop;

    assign pop       = (state_reg == ST_IDLE) && head.valid;
    assign ctrl.pop  = pop;
    assign ctrl.busy = (state_reg != ST_IDLE);

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

    // The history feedback loop is split: products are registered, then the
    // add tree closes the step from the registered products.
    assign sum = 64'(p0_reg) + 64'(p1_reg) + 64'(p2_reg) + 64'(p3_reg) + 64'(carry_reg);

    // Only the low word of the seed product is kept.
    assign seed_prod = s_reg * 32'(mwc_pkg::SEED_MUL);
    assign seed_val  = seed_prod - 32'd1;

    always_ff @(posedge clk)
    begin
        p0_reg <= 45'(h_reg[0]) * 45'(mwc_pkg::MUL0);
        p1_reg <= 43'(h_reg[1]) * 43'(mwc_pkg::MUL1);
        p2_reg <= 43'(h_reg[2]) * 43'(mwc_pkg::MUL2);
        p3_reg <= 63'(h_reg[3]) * 63'(mwc_pkg::MUL3);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        warm_next      = warm_reg;
        h_next         = h_reg;
        carry_next     = carry_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg && out_stall;
        word_next      = word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cnt_next = '0;
                    if (head.cmd.code == mwc_pkg::CMD_RESEED)
                    begin
                        s_next     = head.cmd.seed;
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        warm_next  = 1'b0;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_SEED:
            begin
                // Seed words enter at the carry end; after five shifts the
                // first one sits in the youngest history word.
                h_next[0]  = h_reg[1];
                h_next[1]  = h_reg[2];
                h_next[2]  = h_reg[3];
                h_next[3]  = carry_reg;
                carry_next = seed_val;
                s_next     = seed_val;
                if (cnt_reg == mwc_pkg::SEED_WORDS - 5'd1)
                begin
                    cnt_next   = '0;
                    warm_next  = 1'b1;
                    state_next = ST_PROD;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_PROD:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (warm_reg || !out_valid_reg || !out_stall)
                begin
                    h_next[3]  = h_reg[2];
                    h_next[2]  = h_reg[1];
                    h_next[1]  = h_reg[0];
                    h_next[0]  = sum[31:0];
                    carry_next = sum[63:32];
                    if (warm_reg)
                    begin
                        if (cnt_reg == mwc_pkg::WARMUP_STEPS - 5'd1)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 5'd1;
                            state_next = ST_PROD;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        word_next      = sum[31:0];
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            warm_reg      <= 1'b0;
            h_reg[0]      <= mwc_pkg::RESET_H0;
            h_reg[1]      <= mwc_pkg::RESET_H1;
            h_reg[2]      <= mwc_pkg::RESET_H2;
            h_reg[3]      <= mwc_pkg::RESET_H3;
            carry_reg     <= mwc_pkg::RESET_CARRY;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            warm_reg      <= warm_next;
            h_reg         <= h_next;
            carry_reg     <= carry_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
            word_reg      <= word_next;
        end
    end

endmodule

// ===== rtl/multiply_with_carry_rng_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_with_carry_rng_top
// Five-word multiply-with-carry random number generator.
//
// Input channel (in_valid / in_stall, command, seed): a transaction with
// command 0 asks for the next random word, command 1 reseeds from seed and
// returns nothing. Output channel (out_valid / out_stall, random_word)
// carries one word per next command, in order.
// A command queue decouples input acceptance from the generator core.
// A next command is taken from the queue, its products are registered, and
// the add tree then writes its word into the output register. This split is
// set by the history feedback loop through the 31-bit multiplier and the
// five-term add. A reseed occupies the core while it is taken, for 5 seed
// multiplies, then for 19 warmup steps, each a product state and an add-tree
// state.
// Reset loads the fixed default state and empties the queue.
// While out_stall is high the word is held; the core waits with the next
// word's step pending (warmup steps still run), and the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module multiply_with_carry_rng_top #(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [mwc_pkg::WORD_W-1:0] seed,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mwc_pkg::WORD_W-1:0] random_word
);

    mwc_pkg::queue_head_t head;
    mwc_pkg::core_ctrl_t  ctrl;

    mwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .seed     (seed),
        .head     (head),
        .ctrl     (ctrl)
    );

    mwc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .ctrl        (ctrl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    // The core takes a command only when the queue holds one.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> head.valid)
        else $error("core popped an empty queue");

    // Taking a command starts core activity.
    a_pop_starts_core: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> ctrl.busy)
        else $error("core did not start after taking a command");

    // A new word only comes out of a step that the core was running.
    a_word_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.busy))
        else $error("output word appeared without a generator step");

    // The core is never busy and ready to take a command at once.
    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> !ctrl.pop)
        else $error("core took a command while busy");

endmodule

// ===== tb/sv/tb_multiply_with_carry_rng_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiply_with_carry_rng_top
// Self-checking bench for the five-word multiply-with-carry generator.
//
// A short table of directed commands (next words right after reset, reseeds
// with extreme seeds, back-to-back reseeds, seed bits toggled during next)
// is followed by random command streams. Every accepted transaction updates
// a local copy of the generator state, and each word on the output channel
// is compared with the oldest predicted word. Both channels idle at random
// in the first two of three phases, and the receiver holds off long enough to fill the queue.
// ----------------------------------------------------------------------------
module tb_multiply_with_carry_rng_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;
    localparam int DIRECTED_LEN = 22;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       command;
    logic [mwc_pkg::WORD_W-1:0] seed;
    logic                       out_valid;
    logic                       out_stall;
    logic [mwc_pkg::WORD_W-1:0] random_word;

    // Local copy of the generator state.
    logic [mwc_pkg::WORD_W-1:0] gen_history [4];
    logic [mwc_pkg::WORD_W-1:0] gen_carry;

    logic [mwc_pkg::WORD_W-1:0] expected_words [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  hold_left;
    int  cycle_count;
    int  mismatch_count;
    int  words_checked;
    int  next_sent;
    int  reseed_sent;

    mwc_pkg::cmd_t directed_rows [DIRECTED_LEN];

    multiply_with_carry_rng_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .seed        (seed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic logic [mwc_pkg::WORD_W-1:0] advance_generator();
        logic [63:0] sum;
        begin
            sum = 64'(gen_history[0]) * 64'(mwc_pkg::MUL0)
                + 64'(gen_history[1]) * 64'(mwc_pkg::MUL1)
                + 64'(gen_history[2]) * 64'(mwc_pkg::MUL2)
                + 64'(gen_history[3]) * 64'(mwc_pkg::MUL3)
                + 64'(gen_carry);
            gen_history[3] = gen_history[2];
            gen_history[2] = gen_history[1];
            gen_history[1] = gen_history[0];
            gen_history[0] = sum[31:0];
            gen_carry      = sum[63:32];
            return sum[31:0];
        end
    endfunction

    task automatic reseed_generator(input logic [mwc_pkg::WORD_W-1:0] value);
        logic [mwc_pkg::WORD_W-1:0] s;
        begin
            s = value;
            for (int i = 0; i < 5; i++)
            begin
                s = 32'(64'(s) * 64'(mwc_pkg::SEED_MUL) - 64'd1);
                if (i < 4)
                    gen_history[i] = s;
                else
                    gen_carry = s;
            end
            for (int i = 0; i < int'(mwc_pkg::WARMUP_STEPS); i++)
                void'(advance_generator());
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input mwc_pkg::cmd_code_t code,
                                input logic [mwc_pkg::WORD_W-1:0] value);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            command  <= code;
            seed     <= value;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            if (code == mwc_pkg::CMD_RESEED)
            begin
                reseed_generator(value);
                reseed_sent++;
            end
            else
            begin
                expected_words.push_back(advance_generator());
                next_sent++;
            end
            @(negedge clk);
        end
    endtask

    function automatic logic [mwc_pkg::WORD_W-1:0] pick_seed();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       return '0;
                1:       return '1;
                2:       return 32'd1 << $urandom_range(0, 31);
                default: return $urandom();
            endcase
        end
    endfunction

    // Receiver: random stalls, plus long holds on request.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] unexpected word 0x%08h", $realtime, random_word);
            end
            else
            begin
                if (random_word !== expected_words[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] random_word mismatch: expected 0x%08h, got 0x%08h",
                                 $realtime, expected_words[0], random_word);
                end
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        in_valid       = 1'b0;
        command        = mwc_pkg::CMD_NEXT;
        seed           = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 29;
        recv_stall_pct = 51;
        hold_request   = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        words_checked  = 0;
        next_sent      = 0;
        reseed_sent    = 0;

        gen_history[0] = mwc_pkg::RESET_H0;
        gen_history[1] = mwc_pkg::RESET_H1;
        gen_history[2] = mwc_pkg::RESET_H2;
        gen_history[3] = mwc_pkg::RESET_H3;
        gen_carry      = mwc_pkg::RESET_CARRY;

        // Words from the reset state first, then extreme seeds, back-to-back
        // reseeds, and next commands with the ignored seed field toggled.
        directed_rows = '{
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'hffffffff},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'ha5a5a5a5},
            '{mwc_pkg::CMD_RESEED, 32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_RESEED, 32'hffffffff},
            '{mwc_pkg::CMD_NEXT,   32'hffffffff},
            '{mwc_pkg::CMD_RESEED, 32'h00000001},
            '{mwc_pkg::CMD_RESEED, 32'h80000000},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'h55555555},
            '{mwc_pkg::CMD_RESEED, 32'h7fffffff},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'hffffffff},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_RESEED, 32'h12345678},
            '{mwc_pkg::CMD_RESEED, 32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'h00000000},
            '{mwc_pkg::CMD_NEXT,   32'haaaaaaaa},
            '{mwc_pkg::CMD_NEXT,   32'h00000000}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_command(directed_rows[i].code, directed_rows[i].seed);

        hold_request = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 51;
                recv_stall_pct = 29;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_request   = 1'b1;
            end
            if ($urandom_range(0, 99) < 8)
                send_command(mwc_pkg::CMD_RESEED, pick_seed());
            else
                send_command(mwc_pkg::CMD_NEXT, $urandom());
        end
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
            mismatch_count++;

        $display("Ran %0d next and %0d reseed commands; %0d words compared, %0d errors.",
                 next_sent, reseed_sent, words_checked, mismatch_count);
        $display("Idle phases on both channels and long output holds were exercised.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
